// File: design/prba_pkg.sv
// Shared types and constants for the point rotation block.
// Used by the sine/cosine pipeline, the top level and the port checker.
`default_nettype none

package prba_pkg;

	// Axis codes carried with each beat.
	typedef enum logic [1:0] {
		AXIS_Z    = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	// CORDIC datapath: 24 rotations on values with 30 fraction bits.
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_FRAC  = 30;
	localparam int CORDIC_W     = 33;
	// Sine and cosine leave the pipeline with 16 fraction bits, signed.
	localparam int SC_FRAC      = 16;
	localparam int SC_W         = 18;
	localparam int RND_SHIFT    = CORDIC_FRAC - SC_FRAC;

	localparam logic signed [CORDIC_W-1:0] INV_GAIN   = 33'sd652032874;
	localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = 33'sd8192;

	// Registers from the input beat to the output register, inclusive:
	// capture, one per rotation, rounding, multiply, sum, output.
	localparam int PIPE_DEPTH = CORDIC_STEPS + 5;

	// atan(2^-i) in units of 2^-32 of a full turn.
	localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

endpackage

`default_nettype wire

// File: design/prba_in_if.sv
// Input channel of the point rotation block: one point, angle and axis per beat.
// Depends on prba_pkg for nothing; widths come from its parameters.
`default_nettype none

interface prba_in_if #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic        [ANGLE_WIDTH-1:0] angle;
	logic        [1:0]             axis_select;

	modport source (output valid, point_x, point_y, angle, axis_select, input ready);
	modport sink   (input valid, point_x, point_y, angle, axis_select, output ready);
endinterface

`default_nettype wire

// File: design/prba_out_if.sv
// Output channel of the point rotation block: one rotated point per beat.
// Widths follow COORD_WIDTH; no package dependency.
`default_nettype none

interface prba_out_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                        valid;
	logic                        ready;
	logic signed [COORD_WIDTH:0] rot_x;
	logic signed [COORD_WIDTH:0] rot_y;

	modport source (output valid, rot_x, rot_y, input ready);
	modport sink   (input valid, rot_x, rot_y, output ready);
endinterface

`default_nettype wire

// File: design/point_rotate_by_angle_core.sv
// Top level of the point rotation block: sine/cosine pipeline, multiply, sum, output.
// Depends on prba_pkg, prba_in_if, prba_out_if and prba_sincos.
//
// Rotates a signed point by a binary angle (2^ANGLE_WIDTH is one full turn) about
// the selected axis and returns one point per input beat. The block takes one
// beat in every cycle while the output does not stall and holds 29 beats in flight.
// The pipeline is the 24-stage CORDIC pipeline plus capture, rounding, multiply, sum
// and output registers. All stages advance together: the input is ready whenever the
// output register is empty or is being taken, so a stall on the output holds the whole
// pipeline without losing or repeating a beat. Products are exact and the sums are
// truncated toward zero; the unused axis code returns zero.
`default_nettype none

module point_rotate_by_angle_core #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	prba_in_if.sink   points,
	prba_out_if.source rotated
);
	localparam int CW     = COORD_WIDTH;
	localparam int OW     = COORD_WIDTH + 1;
	localparam int SW     = prba_pkg::SC_W;
	localparam int MW     = CW + SW;
	localparam int PW     = CW + SW + 1;
	localparam int SIDE_W = 2 * CW + 2;

	localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((1 << prba_pkg::SC_FRAC) - 1);

	logic en;

	// Sine/cosine pipeline with the point and axis as sideband.
	logic                 sc_valid;
	logic signed [SW-1:0] sc_cos;
	logic signed [SW-1:0] sc_sin;
	logic [SIDE_W-1:0]    sc_side;

	prba_sincos #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.SIDE_W      (SIDE_W)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (points.valid),
		.angle     (points.angle),
		.side_in   ({points.axis_select, points.point_y, points.point_x}),
		.out_valid (sc_valid),
		.cos_val   (sc_cos),
		.sin_val   (sc_sin),
		.side_out  (sc_side)
	);

	logic signed [CW-1:0] sc_x;
	logic signed [CW-1:0] sc_y;
	prba_pkg::axis_t      sc_axis;

	assign sc_x    = sc_side[CW-1:0];
	assign sc_y    = sc_side[2*CW-1:CW];
	assign sc_axis = prba_pkg::axis_t'(sc_side[SIDE_W-1 -: 2]);

	// Multiply stage: the four exact products.
	logic                 v_s1;
	logic signed [MW-1:0] xc_s1;
	logic signed [MW-1:0] ys_s1;
	logic signed [MW-1:0] yc_s1;
	logic signed [MW-1:0] xs_s1;
	logic signed [CW-1:0] x_s1;
	logic signed [CW-1:0] y_s1;
	prba_pkg::axis_t      axis_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1   <= sc_x * sc_cos;
			ys_s1   <= sc_y * sc_sin;
			yc_s1   <= sc_y * sc_cos;
			xs_s1   <= sc_x * sc_sin;
			x_s1    <= sc_x;
			y_s1    <= sc_y;
			axis_s1 <= sc_axis;
		end
	end

	// Sum stage: a full rotation combines two products, a single axis keeps one.
	logic                 v_s2;
	logic signed [PW-1:0] sx_s2;
	logic signed [PW-1:0] sy_s2;
	logic signed [CW-1:0] x_s2;
	logic signed [CW-1:0] y_s2;
	prba_pkg::axis_t      axis_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (axis_s1 == prba_pkg::AXIS_Z) begin
				sx_s2 <= PW'(xc_s1) + PW'(ys_s1);
				sy_s2 <= PW'(yc_s1) - PW'(xs_s1);
			end else begin
				sx_s2 <= PW'(xc_s1);
				sy_s2 <= PW'(yc_s1);
			end
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			axis_s2 <= axis_s1;
		end
	end

	// Output stage: truncate toward zero, then pick per axis.
	logic signed [PW-1:0] tx;
	logic signed [PW-1:0] ty;
	logic signed [OW-1:0] qx;
	logic signed [OW-1:0] qy;
	logic signed [OW-1:0] rx;
	logic signed [OW-1:0] ry;

	assign tx = sx_s2 + (sx_s2[PW-1] ? TRUNC_BIAS : '0);
	assign ty = sy_s2 + (sy_s2[PW-1] ? TRUNC_BIAS : '0);
	assign qx = OW'(tx >>> prba_pkg::SC_FRAC);
	assign qy = OW'(ty >>> prba_pkg::SC_FRAC);

	always_comb begin
		unique case (axis_s2)
			prba_pkg::AXIS_Z: begin
				rx = qx;
				ry = qy;
			end
			prba_pkg::AXIS_X: begin
				rx = OW'(x_s2);
				ry = qy;
			end
			prba_pkg::AXIS_Y: begin
				rx = qx;
				ry = OW'(y_s2);
			end
			default: begin
				rx = '0;
				ry = '0;
			end
		endcase
	end

	logic                 v_s3;
	logic signed [OW-1:0] rx_s3;
	logic signed [OW-1:0] ry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s3 <= rx;
			ry_s3 <= ry;
		end
	end

	// The whole pipeline moves when the output register is free or being taken.
	assign en            = !v_s3 || rotated.ready;
	assign points.ready  = en;
	assign rotated.valid = v_s3;
	assign rotated.rot_x = rx_s3;
	assign rotated.rot_y = ry_s3;

endmodule

`default_nettype wire

// File: design/prba_sincos.sv
// Pipelined CORDIC sine/cosine with quadrant folding and a sideband that rides along.
// Depends on prba_pkg for the arctangent table and datapath widths.
`default_nettype none

module prba_sincos #(
	parameter int ANGLE_WIDTH = 16,
	parameter int SIDE_W      = 34
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic [ANGLE_WIDTH-1:0]            angle,
	input  wire logic [SIDE_W-1:0]                 side_in,
	output logic                                   out_valid,
	output logic signed [prba_pkg::SC_W-1:0]       cos_val,
	output logic signed [prba_pkg::SC_W-1:0]       sin_val,
	output logic [SIDE_W-1:0]                      side_out
);
	localparam int ZW    = prba_pkg::CORDIC_W;
	localparam int STEPS = prba_pkg::CORDIC_STEPS;
	localparam int SW    = prba_pkg::SC_W;

	// Rotation pipeline: index 0 is the capture stage, index i+1 follows rotation i.
	logic                 v_s    [0:STEPS];
	logic signed [ZW-1:0] x_s    [0:STEPS];
	logic signed [ZW-1:0] y_s    [0:STEPS];
	logic signed [ZW-1:0] z_s    [0:STEPS];
	logic [1:0]           q_s    [0:STEPS];
	logic [SIDE_W-1:0]    side_s [0:STEPS];

	// Rounding stage registers.
	logic                 v_s25;
	logic signed [SW-1:0] cos_s25;
	logic signed [SW-1:0] sin_s25;
	logic [SIDE_W-1:0]    side_s25;

	// Capture stage: quadrant from the top angle bits, residual scaled to 2^-32 turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= prba_pkg::INV_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= {{(ZW-30){1'b0}}, angle[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
			q_s[0]    <= angle[ANGLE_WIDTH-1 -: 2];
			side_s[0] <= side_in;
		end
	end

	// One rotation per stage; the residual angle sign picks the direction.
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [ZW-1:0] dx;
		logic signed [ZW-1:0] dy;
		logic signed [ZW-1:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed({1'b0, prba_pkg::ATAN_TURN[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end
				q_s[i+1]    <= q_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// Round half up to 16 fraction bits, then unfold the quadrant.
	logic signed [ZW-1:0] x_rnd;
	logic signed [ZW-1:0] y_rnd;
	logic signed [SW-1:0] c0;
	logic signed [SW-1:0] s0;
	logic signed [SW-1:0] c_fold;
	logic signed [SW-1:0] s_fold;

	assign x_rnd = x_s[STEPS] + prba_pkg::ROUND_BIAS;
	assign y_rnd = y_s[STEPS] + prba_pkg::ROUND_BIAS;
	assign c0    = SW'(x_rnd >>> prba_pkg::RND_SHIFT);
	assign s0    = SW'(y_rnd >>> prba_pkg::RND_SHIFT);

	always_comb begin
		unique case (q_s[STEPS])
			2'd0: begin
				c_fold = c0;
				s_fold = s0;
			end
			2'd1: begin
				c_fold = -s0;
				s_fold = c0;
			end
			2'd2: begin
				c_fold = -c0;
				s_fold = -s0;
			end
			default: begin
				c_fold = s0;
				s_fold = -c0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s25 <= 1'b0;
		end else if (en) begin
			v_s25 <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s25  <= c_fold;
			sin_s25  <= s_fold;
			side_s25 <= side_s[STEPS];
		end
	end

	assign out_valid = v_s25;
	assign cos_val   = cos_s25;
	assign sin_val   = sin_s25;
	assign side_out  = side_s25;

endmodule

`default_nettype wire

// File: design/prba_checker.sv
// Port-level checks for the point rotation block and the bind that attaches them.
// Depends on prba_pkg for the pipeline depth.
`default_nettype none

module prba_checker #(
	parameter int OW = 17
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [OW-1:0] rot_x,
	input wire logic [OW-1:0] rot_y
);
	localparam int OCC_W = $clog2(prba_pkg::PIPE_DEPTH + 1) + 1;

	logic             in_beat;
	logic             out_beat;
	logic [OCC_W-1:0] occ_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Beats taken but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_beat) - OCC_W'(out_beat);
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y))
		else $error("stalled result changed or dropped");

	// The input never stalls while the output side can move.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled although the output can move");

	// No result without a beat in flight.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result shown with no beat in flight");

	// The pipeline never holds more beats than it has stages.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(prba_pkg::PIPE_DEPTH))
		else $error("more beats in flight than pipeline stages");

endmodule

bind point_rotate_by_angle_core prba_checker #(
	.OW (COORD_WIDTH + 1)
) u_prba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (rotated.valid),
	.out_ready (rotated.ready),
	.rot_x     (rotated.rot_x),
	.rot_y     (rotated.rot_y)
);

`default_nettype wire

// File: tb/point_rotate_by_angle_core_tb.sv
// Testbench for point_rotate_by_angle_core: drives points through the input channel,
// predicts each rotated point with its own CORDIC model and checks every output beat.
// Depends on prba_pkg, prba_in_if, prba_out_if and the block's RTL.
`timescale 1ns / 1ps

module point_rotate_by_angle_core_tb;

	localparam int XY_W = 16;
	localparam int ANG_W = 16;
	localparam int ROT_STEPS = 24;
	localparam longint START_GAIN = 652032874;
	localparam longint UNIT_Q16 = 65536;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// Arctangent of 2^-i in units of 2^-32 of a full turn.
	localparam longint ARCTAN_TURN [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// One point in flight: the input fields and the rotated point they must give.
	typedef struct {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [ANG_W-1:0]       angle;
		prba_pkg::axis_t        axis;
		logic signed [XY_W:0]   rot_x;
		logic signed [XY_W:0]   rot_y;
	} rotation_t;

	logic clk;
	logic arst_n = 1'b0;

	prba_in_if #(.COORD_WIDTH(XY_W), .ANGLE_WIDTH(ANG_W)) points_if ();
	prba_out_if #(.COORD_WIDTH(XY_W)) rotated_if ();

	point_rotate_by_angle_core #(
		.COORD_WIDTH(XY_W),
		.ANGLE_WIDTH(ANG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_if),
		.rotated(rotated_if)
	);

	rotation_t awaited_points[$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Fills in the rotated point: quadrant fold, 24 CORDIC steps, rounding to
	// 16 fraction bits, exact products and a sum truncated toward zero.
	function automatic rotation_t predict_rotation(rotation_t b);
		longint cx, sy, zr, step_x, step_y, c0, s0, cosv, sinv, px, py, rx, ry;
		cx = START_GAIN;
		sy = 0;
		zr = longint'(b.angle[ANG_W-3:0]) << (32 - ANG_W);
		for (int i = 0; i < ROT_STEPS; i++) begin
			step_x = sy >>> i;
			step_y = cx >>> i;
			if (zr >= 0) begin
				cx = cx - step_x;
				sy = sy + step_y;
				zr = zr - ARCTAN_TURN[i];
			end else begin
				cx = cx + step_x;
				sy = sy - step_y;
				zr = zr + ARCTAN_TURN[i];
			end
		end
		c0 = (cx + 8192) >>> 14;
		s0 = (sy + 8192) >>> 14;
		// The top two angle bits pick the quadrant and swap the roles of sine and cosine.
		case (b.angle[ANG_W-1:ANG_W-2])
			2'd0: begin
				cosv = c0;
				sinv = s0;
			end
			2'd1: begin
				cosv = -s0;
				sinv = c0;
			end
			2'd2: begin
				cosv = -c0;
				sinv = -s0;
			end
			default: begin
				cosv = s0;
				sinv = -c0;
			end
		endcase
		px = b.x;
		py = b.y;
		rx = 0;
		ry = 0;
		case (b.axis)
			prba_pkg::AXIS_Z: begin
				rx = (px * cosv + py * sinv) / UNIT_Q16;
				ry = (py * cosv - px * sinv) / UNIT_Q16;
			end
			prba_pkg::AXIS_X: begin
				rx = px;
				ry = (py * cosv) / UNIT_Q16;
			end
			prba_pkg::AXIS_Y: begin
				rx = (px * cosv) / UNIT_Q16;
				ry = py;
			end
			default: begin
			end
		endcase
		b.rot_x = rx[XY_W:0];
		b.rot_y = ry[XY_W:0];
		return b;
	endfunction

	task automatic report_fault(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Offers one point, with a random idle gap first, and records its expected
	// result once the beat is taken. Starts and returns at a rising edge.
	task automatic send_point(input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y,
			input logic [ANG_W-1:0] ang, input prba_pkg::axis_t axis);
		rotation_t beat;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			points_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		beat.x = x;
		beat.y = y;
		beat.angle = ang;
		beat.axis = axis;
		beat = predict_rotation(beat);
		points_if.valid <= 1'b1;
		points_if.point_x <= x;
		points_if.point_y <= y;
		points_if.angle <= ang;
		points_if.axis_select <= axis;
		@(negedge clk);
		while (!points_if.ready)
			@(negedge clk);
		@(posedge clk);
		awaited_points.push_back(beat);
	endtask

	// Sender stays quiet until every expected point has come back.
	task automatic drain_results();
		points_if.valid <= 1'b0;
		do @(posedge clk); while (awaited_points.size() != 0);
	endtask

	// Corner coordinates, octant and quarter-turn angles, and every axis code.
	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		send_point(16'sh7FFF, 16'sh7FFF, 16'h2000, prba_pkg::AXIS_Z);
		send_point(16'sh8000, 16'sh8000, 16'h2000, prba_pkg::AXIS_Z);
		send_point(16'sh8000, 16'sh7FFF, 16'h6000, prba_pkg::AXIS_Z);
		send_point(16'sd12345, -16'sd23456, 16'h0000, prba_pkg::AXIS_Z);
		send_point(16'sd12345, -16'sd23456, 16'h4000, prba_pkg::AXIS_Z);
		send_point(16'sd12345, -16'sd23456, 16'h8000, prba_pkg::AXIS_Z);
		send_point(16'sd12345, -16'sd23456, 16'hC000, prba_pkg::AXIS_Z);
		send_point(16'sh8000, 16'sh7FFF, 16'hFFFF, prba_pkg::AXIS_Z);
		send_point(16'sd1000, -16'sd1000, 16'h0001, prba_pkg::AXIS_Z);
		send_point(16'sh8000, 16'sh8000, 16'h8000, prba_pkg::AXIS_X);
		send_point(16'sh7FFF, 16'sh8000, 16'h4000, prba_pkg::AXIS_X);
		send_point(16'sh8000, 16'sh7FFF, 16'h8000, prba_pkg::AXIS_Y);
		send_point(16'sh7FFF, 16'sh7FFF, 16'h3FFF, prba_pkg::AXIS_Y);
		send_point(16'sh7FFF, 16'sh8000, 16'h1234, prba_pkg::AXIS_NONE);
		send_point(-16'sd1, -16'sd1, 16'hA5A5, prba_pkg::AXIS_Z);
		send_point(16'sd0, 16'sd0, 16'h5555, prba_pkg::AXIS_Z);
		send_point(-16'sd1, 16'sd1, 16'hC000, prba_pkg::AXIS_X);
		send_point(16'sd1, -16'sd1, 16'h4001, prba_pkg::AXIS_Y);
		send_point(16'sh7FFF, 16'sd0, 16'h7FFF, prba_pkg::AXIS_Z);
		send_point(16'sd0, 16'sh8000, 16'hBFFF, prba_pkg::AXIS_NONE);
		drain_results();
	endtask

	// Random points under one idle and stall setting. Some beats use corner
	// coordinates or angles right at a quarter-turn boundary.
	task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
			input int unsigned count);
		logic signed [XY_W-1:0] corners [5] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1};
		logic signed [XY_W-1:0] x, y;
		logic [ANG_W-1:0] ang;
		int unsigned pick;
		send_idle_pct = idle;
		recv_stall_pct <= stall;
		repeat (count) begin
			pick = $urandom_range(9);
			x = XY_W'($urandom);
			y = XY_W'($urandom);
			ang = ANG_W'($urandom);
			if (pick == 0) begin
				x = corners[$urandom_range(4)];
				y = corners[$urandom_range(4)];
			end else if (pick == 1) begin
				ang = ANG_W'(($urandom_range(3) << (ANG_W - 2)) + $urandom_range(2) - 1);
			end
			send_point(x, y, ang, prba_pkg::axis_t'($urandom_range(3)));
		end
		drain_results();
	endtask

	// The receiver holds off for a long stretch while points keep coming, so the
	// pipeline fills and the input has to stall.
	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_asked <= hold_asked + 1;
		repeat (120)
			send_point(XY_W'($urandom), XY_W'($urandom), ANG_W'($urandom),
				prba_pkg::axis_t'($urandom_range(3)));
		drain_results();
	endtask

	// Output ready: a counted hold-off when one is asked for, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			rotated_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rotated_if.ready <= 1'b0;
		end else begin
			rotated_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each output beat is compared with the oldest expected point. Sampling on the
	// falling edge sees the values that the next rising edge will take.
	always @(negedge clk) begin
		rotation_t want;
		if (arst_n && rotated_if.valid && rotated_if.ready) begin
			if (awaited_points.size() == 0) begin
				report_fault($sformatf("unexpected beat: rot_x=%0d rot_y=%0d",
					rotated_if.rot_x, rotated_if.rot_y));
			end else begin
				want = awaited_points.pop_front();
				if (rotated_if.rot_x !== want.rot_x)
					report_fault($sformatf(
						"rot_x mismatch (x=%0d y=%0d angle=%0d axis=%s): expected %0d, got %0d",
						want.x, want.y, want.angle, want.axis.name(), want.rot_x,
						rotated_if.rot_x));
				if (rotated_if.rot_y !== want.rot_y)
					report_fault($sformatf(
						"rot_y mismatch (x=%0d y=%0d angle=%0d axis=%s): expected %0d, got %0d",
						want.x, want.y, want.angle, want.axis.name(), want.rot_y,
						rotated_if.rot_y));
			end
		end
	end

	// Main sequence: reset, directed points, then random phases with back-pressure.
	initial begin
		points_if.valid = 1'b0;
		points_if.point_x = '0;
		points_if.point_y = '0;
		points_if.angle = '0;
		points_if.axis_select = prba_pkg::AXIS_Z;
		rotated_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_phase(0, 0, 400);
		test_random_phase(74, 0, 400);
		test_backpressure_fill();
		test_random_phase(0, 74, 400);
		test_random_phase(35, 35, 400);
		// Let any stray beat show up before the verdict.
		repeat (prba_pkg::PIPE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[point_rotate_by_angle_core] OK");
		else
			$display("[point_rotate_by_angle_core] ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("[point_rotate_by_angle_core] ERROR");
		$finish;
	end

endmodule
